// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file otts_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, muted while reset is high.
`define OTTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("otts assertion failed");

// Condition that must never hold at a clock edge outside reset.
`define OTTS_NEVER(lbl, clk, rst, cond) `OTTS_ASSERT(lbl, clk, rst, !(cond))

`endif

// ----- rtl/otts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otts_pkg
// Types, constants and codes shared by the one-shot timer table and
// inactivity sleep unit.
// ----------------------------------------------------------------------------
package otts_pkg;

   localparam int TIMER_SLOTS   = 16;
   localparam int SERVICE_COUNT = 16;
   localparam int SLOT_W        = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   localparam int SEC_PER_MINUTE = 60;
   localparam int MS_PER_SECOND  = 1000;
   localparam int MS_PER_MINUTE  = SEC_PER_MINUTE * MS_PER_SECOND;

   localparam int READY_W  = 16;
   localparam logic [READY_W-1:0] SVC_MASK = (SERVICE_COUNT >= READY_W) ?
      {READY_W{1'b1}} : READY_W'((64'd1 << SERVICE_COUNT) - 64'd1);

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TIMER_SLOTS - 1);
   localparam logic [31:0]       LIMIT_RST  = 32'(MS_PER_MINUTE);

   // Configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_INACTIVITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_MASK   = 2'd1;

   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_ACTIVITY = 2'd1,
      KIND_SERVICE  = 2'd2,
      KIND_SCHEDULE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  service_index;
      logic        ready_req;
      logic [15:0] delay_minutes;
      logic [7:0]  event_id;
   } req_type;

   typedef struct packed {
      logic       fired;
      logic [7:0] fired_id;
      logic       sleep_request;
      logic       table_full;
      logic       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STATUS,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic load;         // capture the accepted request
      logic scan_step;    // process one timer slot
      logic status_step;  // bump inactivity, emit tick status
      logic exec_step;    // perform a non-tick request
   } cmd_type;

   typedef struct packed {
      kind_type in_kind;  // kind on the request port
      logic     out_free; // output register can take a result this cycle
      logic     scan_last;
   } sts_type;

endpackage

// ----- rtl/otts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otts_ctrl
// Sequencer: accepts one request, walks the slot scan for ticks or runs other
// requests, and steps only when the output register has room.
// ----------------------------------------------------------------------------
module otts_ctrl import otts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (sts.in_kind == KIND_TICK) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (sts.out_free && sts.scan_last) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = sts.out_free;
         end
         ST_STATUS: begin
            cmd.status_step = sts.out_free;
         end
         ST_EXEC: begin
            cmd.exec_step = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- rtl/otts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otts_dp
// Datapath: timer slot registers, inactivity counter, ready bits, control
// registers and the result output register.
// ----------------------------------------------------------------------------
module otts_dp import otts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  cmd_type               cmd,
   output sts_type               sts
);

   req_type                req_ff;
   logic [SLOT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic [TIMER_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [31:0]            slot_rem_ff [TIMER_SLOTS];
   logic [7:0]             slot_evt_ff [TIMER_SLOTS];
   logic [31:0]            inactive_ff, inactive_in;
   logic [READY_W-1:0]     ready_bits_ff, ready_bits_in;
   logic [15:0]            inact_min_ff;
   logic [15:0]            reg_mask_ff;
   logic [31:0]            limit_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic              slot_we;
   logic [SLOT_W-1:0] slot_waddr;
   logic [31:0]       slot_wrem;
   logic [7:0]        slot_wevt;

   logic              out_free;
   logic [31:0]       cur_rem;
   logic [31:0]       dec_rem;
   logic              cur_valid;
   logic              any_free;
   logic [SLOT_W-1:0] free_idx;
   logic [31:0]       inc_inactive;
   logic              all_ready;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign cur_rem   = slot_rem_ff[scan_idx_ff];
   assign cur_valid = slot_valid_ff[scan_idx_ff];
   assign dec_rem   = (cur_rem != 32'd0) ? cur_rem - 32'd1 : cur_rem;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end
   assign any_free = ~&slot_valid_ff;

   assign inc_inactive = (inactive_ff == 32'hFFFF_FFFF) ? inactive_ff : inactive_ff + 32'd1;
   assign all_ready    = ((reg_mask_ff & SVC_MASK & ~ready_bits_ff) == '0);

   always_comb begin
      scan_idx_in   = scan_idx_ff;
      slot_valid_in = slot_valid_ff;
      inactive_in   = inactive_ff;
      ready_bits_in = ready_bits_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      slot_we       = 1'b0;
      slot_waddr    = scan_idx_ff;
      slot_wrem     = dec_rem;
      slot_wevt     = req_ff.event_id;

      if (cmd.load) begin
         scan_idx_in = '0;
      end

      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + SLOT_W'(1);
         if (cur_valid) begin
            slot_we   = 1'b1;
            slot_wevt = slot_evt_ff[scan_idx_ff];
            if (dec_rem == 32'd0) begin
               // expire: free the slot and report it
               slot_valid_in[scan_idx_ff] = 1'b0;
               rsp_valid_in               = 1'b1;
               rsp_data_in                = '0;
               rsp_data_in.fired          = 1'b1;
               rsp_data_in.fired_id       = slot_evt_ff[scan_idx_ff];
            end
         end
      end

      if (cmd.status_step) begin
         inactive_in               = inc_inactive;
         rsp_valid_in              = 1'b1;
         rsp_data_in               = '0;
         rsp_data_in.sleep_request = (inc_inactive > limit_ff) && all_ready;
         rsp_data_in.last          = 1'b1;
      end

      if (cmd.exec_step) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = '0;
         rsp_data_in.last = 1'b1;
         case (req_ff.kind)
            KIND_ACTIVITY: begin
               inactive_in = '0;
            end
            KIND_SERVICE: begin
               if (32'(req_ff.service_index) < 32'(SERVICE_COUNT)) begin
                  ready_bits_in[req_ff.service_index] = req_ff.ready_req;
               end
            end
            KIND_SCHEDULE: begin
               if (any_free) begin
                  slot_we                 = 1'b1;
                  slot_waddr              = free_idx;
                  slot_wrem               = 32'(req_ff.delay_minutes) * LIMIT_RST;
                  slot_wevt               = req_ff.event_id;
                  slot_valid_in[free_idx] = 1'b1;
               end else begin
                  rsp_data_in.table_full = 1'b1;
               end
            end
            default: begin
               rsp_data_in.last = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         inactive_ff   <= '0;
         ready_bits_ff <= '0;
         inact_min_ff  <= 16'd1;
         reg_mask_ff   <= '0;
         limit_ff      <= LIMIT_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         inactive_ff   <= inactive_in;
         ready_bits_ff <= ready_bits_in;
         rsp_valid_ff  <= rsp_valid_in;
         limit_ff      <= 32'(inact_min_ff) * LIMIT_RST;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_INACTIVITY: inact_min_ff <= csr_data;
               CSR_REG_MASK:   reg_mask_ff  <= csr_data;
               default: begin
                  inact_min_ff <= inact_min_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      scan_idx_ff <= scan_idx_in;
      rsp_data_ff <= rsp_data_in;
      if (slot_we) begin
         slot_rem_ff[slot_waddr] <= slot_wrem;
         slot_evt_ff[slot_waddr] <= slot_wevt;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign sts.in_kind   = req_data.kind;
   assign sts.out_free  = out_free;
   assign sts.scan_last = (scan_idx_ff == LAST_SLOT);

endmodule

// ----- rtl/oneshot_timer_table_inactivity_sleep_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oneshot_timer_table_inactivity_sleep_unit
// One-shot timer table and inactivity counter driven by millisecond ticks;
// reports expired timers and requests sleep.
// ----------------------------------------------------------------------------
//  channel   direction  payload    handshake
//  req_      in         req_type   req_valid / req_ready
//  rsp_      out        rsp_type   rsp_valid / rsp_ready
//  csr_      in         index,data csr_valid / csr_ready (always ready)
//
//  A tick is accepted, then walks the scan one slot per step, then gives
//  the status result. Other items are accepted, then executed.
//  Each scan or result step waits while the output register is held by
//  rsp_ready low; a new item is accepted while the last result waits.
//  Synchronous reset takes effect at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module oneshot_timer_table_inactivity_sleep_unit import otts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   otts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   otts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ----- rtl/otts_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otts_chk
// Port-level checks for the timer table unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module otts_chk import otts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result transaction holds its payload
   `OTTS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // one request at a time: ready drops right after an accepted transaction
   `OTTS_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready)

   // a fired timer result is never the final result of its item
   `OTTS_NEVER(a_fired_not_last, clock, reset, rsp_valid && rsp_data.fired && rsp_data.last)

   // id is zero on non-fired results
   `OTTS_NEVER(a_id_zero, clock, reset, rsp_valid && !rsp_data.fired && rsp_data.fired_id != 8'd0)

   // sleep only on a final status result, never with table full
   `OTTS_NEVER(a_sleep_status, clock, reset, rsp_valid && rsp_data.sleep_request && (!rsp_data.last || rsp_data.table_full))

endmodule

bind oneshot_timer_table_inactivity_sleep_unit otts_chk u_otts_chk (.*);
